// ===== hdl/rfsm_pkg.sv =====
// Shared types, widths and constants of the RF power and SWR meter
package rfsm_pkg;

   localparam int DEF_SAMPLES = 60;

   localparam int SAMPLE_W   = 12;
   localparam int SAMPLE_MAX = 4095;
   localparam int VOLT_W     = 18;
   localparam int PWR_W      = 18;
   localparam int SWR_W      = 12;
   localparam int MS_W       = 16;

   localparam int GAIN_W     = 15;
   localparam int DROP_W     = 16;
   localparam int HOLD_W     = 16;
   localparam int ALERT_W    = 12;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // volts = sum * 33 * 2^16 / (SAMPLES * 40950)
   localparam int VOLT_SCALE = 33;
   localparam int VSCALE_W   = 6;
   localparam int FRAC_W     = 16;
   localparam int VDEN_SCALE = 40950;

   localparam int COMP_W    = VOLT_W + 1;
   localparam int SQ_W      = 2 * COMP_W;
   localparam int GK_W      = 22;
   localparam int PROD_W    = SQ_W + GK_W;
   localparam int PWR_SHIFT = 40;
   localparam int PWR_MAX   = (1 << PWR_W) - 1;

   localparam int SWR_DEN_W = COMP_W + 1;
   localparam int SWR_NUM_W = 26;
   localparam int SCNT_W    = $clog2(SWR_NUM_W + 1);
   localparam int GAM_W     = 27;

   localparam int HUNDRED    = 100;
   localparam int GAMMA_NUM  = 95;
   localparam int V_COMP_MIN = 655;
   localparam int V_PWR_MIN  = 1310;
   localparam int V_SWR_MIN  = 6553;
   localparam int SWR_ONE    = 100;
   localparam int SWR_CAP    = 999;
   localparam int SHOWN_MIN  = 40;
   localparam int ALERT_PWR  = 100;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_COUPLING_GAIN = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIODE_DROP    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TIME_MS  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_SWR     = 4'd3;

   typedef struct packed {
      logic                command;
      logic [SAMPLE_W-1:0] fwd_sample;
      logic [SAMPLE_W-1:0] ref_sample;
   } rfsm_req_type;

   typedef struct packed {
      logic [VOLT_W-1:0] fwd_voltage;
      logic [VOLT_W-1:0] ref_voltage;
      logic [PWR_W-1:0]  fwd_power;
      logic [PWR_W-1:0]  ref_power;
      logic [SWR_W-1:0]  swr_value;
      logic [PWR_W-1:0]  held_power;
      logic [SWR_W-1:0]  held_swr;
      logic              swr_shown;
      logic              alert;
   } rfsm_rsp_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  coupling_gain;
      logic [DROP_W-1:0]  diode_drop;
      logic [HOLD_W-1:0]  hold_time_ms;
      logic [ALERT_W-1:0] alert_swr;
   } rfsm_cfg_type;

   typedef struct packed {
      logic [VOLT_W-1:0] fwd_voltage;
      logic [VOLT_W-1:0] ref_voltage;
      logic [PWR_W-1:0]  fwd_power;
      logic [PWR_W-1:0]  ref_power;
      logic [SWR_W-1:0]  swr_value;
   } rfsm_calc_type;

   localparam rfsm_cfg_type CFG_RESET = '{
      coupling_gain: 15'd3174,
      diode_drop:    16'd11141,
      hold_time_ms:  16'd3000,
      alert_swr:     12'd300
   };

endpackage

// ===== hdl/rfsm_calc.sv =====
// Bit-serial datapath: voltage division, power multiply and SWR division
module rfsm_calc
   import rfsm_pkg::*;
#(
   parameter int SAMPLES = DEF_SAMPLES
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  rfsm_cfg_type                              cfg,
   input  logic                                      start,
   input  logic [$clog2(SAMPLES*SAMPLE_MAX+1)-1:0]   fwd_sum,
   input  logic [$clog2(SAMPLES*SAMPLE_MAX+1)-1:0]   ref_sum,
   output logic                                      done,
   output rfsm_calc_type                             res
);

   localparam int SUM_W  = $clog2(SAMPLES * SAMPLE_MAX + 1);
   localparam int VNUM_W = SUM_W + VSCALE_W;
   localparam int NUM_W  = VNUM_W + FRAC_W;
   localparam int DEN    = SAMPLES * VDEN_SCALE;
   localparam int DEN_W  = $clog2(DEN + 1);
   localparam int STEP_W = $clog2(NUM_W + 1);
   localparam int LANES  = 2;

   typedef enum logic [7:0] {
      C_IDLE  = 8'b0000_0001,
      C_VOLT  = 8'b0000_0010,
      C_COMP  = 8'b0000_0100,
      C_LOAD  = 8'b0000_1000,
      C_SQR   = 8'b0001_0000,
      C_GLOAD = 8'b0010_0000,
      C_GAIN  = 8'b0100_0000,
      C_RES   = 8'b1000_0000
   } calc_state_type;

   calc_state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SCNT_W-1:0] scnt_ff, scnt_in;
   logic              done_ff;

   logic [NUM_W-1:0]  num_ff  [LANES];
   logic [NUM_W-1:0]  num_in  [LANES];
   logic [DEN_W-1:0]  rem_ff  [LANES];
   logic [DEN_W-1:0]  rem_in  [LANES];
   logic [VOLT_W-1:0] vq_ff   [LANES];
   logic [VOLT_W-1:0] vq_in   [LANES];
   logic [COMP_W-1:0] comp_ff [LANES];
   logic [COMP_W-1:0] comp_in [LANES];
   logic [SQ_W-1:0]   sqp_ff  [LANES];
   logic [SQ_W-1:0]   sqp_in  [LANES];
   logic [PROD_W-1:0] pg_ff   [LANES];
   logic [PROD_W-1:0] pg_in   [LANES];

   logic [GK_W-1:0]      gk_ff, gk_in;
   logic [SWR_NUM_W-1:0] snum_ff, snum_in;
   logic [SWR_DEN_W-1:0] sden_ff, sden_in;
   logic [SWR_DEN_W-1:0] srem_ff, srem_in;
   logic [SWR_W-1:0]     squot_ff, squot_in;
   logic                 gamma_ff, gamma_in;
   rfsm_calc_type        res_ff, res_in;

   logic [VNUM_W-1:0]   scaled   [LANES];
   logic [DEN_W:0]      vtrial   [LANES];
   logic [DEN_W:0]      vdiff    [LANES];
   logic                vge      [LANES];
   logic [COMP_W-1:0]   comp_val [LANES];
   logic [COMP_W:0]     sq_sum   [LANES];
   logic [SQ_W:0]       pg_sum   [LANES];
   logic [PWR_W-1:0]    pwr      [LANES];

   logic [SWR_DEN_W-1:0] csum;
   logic [SWR_DEN_W:0]   strial;
   logic [SWR_DEN_W:0]   sdiff;
   logic                 sge;

   assign scaled[0] = VNUM_W'(fwd_sum) * VNUM_W'(VOLT_SCALE);
   assign scaled[1] = VNUM_W'(ref_sum) * VNUM_W'(VOLT_SCALE);

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         vtrial[i] = {rem_ff[i], num_ff[i][NUM_W-1]};
         vge[i]    = vtrial[i] >= (DEN_W+1)'(DEN);
         vdiff[i]  = vtrial[i] - (DEN_W+1)'(DEN);
         comp_val[i] = (vq_ff[i] > VOLT_W'(V_COMP_MIN)) ?
                       COMP_W'(vq_ff[i]) + COMP_W'(cfg.diode_drop) : '0;
         sq_sum[i] = {1'b0, sqp_ff[i][SQ_W-1:COMP_W]} +
                     (sqp_ff[i][0] ? {1'b0, comp_ff[i]} : '0);
         pg_sum[i] = {1'b0, pg_ff[i][PROD_W-1:GK_W]} +
                     (pg_ff[i][0] ? {1'b0, sqp_ff[i]} : '0);
         if (vq_ff[i] <= VOLT_W'(V_PWR_MIN)) begin
            pwr[i] = '0;
         end else if (|pg_ff[i][PROD_W-1:PWR_SHIFT+PWR_W]) begin
            pwr[i] = PWR_W'(PWR_MAX);
         end else begin
            pwr[i] = pg_ff[i][PWR_SHIFT+PWR_W-1:PWR_SHIFT];
         end
      end
   end

   assign csum   = SWR_DEN_W'(comp_ff[0]) + SWR_DEN_W'(comp_ff[1]);
   assign strial = {srem_ff, snum_ff[SWR_NUM_W-1]};
   assign sge    = strial >= {1'b0, sden_ff};
   assign sdiff  = strial - {1'b0, sden_ff};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      scnt_in  = scnt_ff;
      gk_in    = gk_ff;
      snum_in  = snum_ff;
      sden_in  = sden_ff;
      srem_in  = srem_ff;
      squot_in = squot_ff;
      gamma_in = gamma_ff;
      res_in   = res_ff;
      for (int i = 0; i < LANES; i++) begin
         num_in[i]  = num_ff[i];
         rem_in[i]  = rem_ff[i];
         vq_in[i]   = vq_ff[i];
         comp_in[i] = comp_ff[i];
         sqp_in[i]  = sqp_ff[i];
         pg_in[i]   = pg_ff[i];
      end

      case (state_ff)
         C_IDLE: begin
            if (start) begin
               for (int i = 0; i < LANES; i++) begin
                  num_in[i] = {scaled[i], FRAC_W'(0)};
                  rem_in[i] = '0;
               end
               step_in  = STEP_W'(NUM_W);
               state_in = C_VOLT;
            end
         end
         C_VOLT: begin
            for (int i = 0; i < LANES; i++) begin
               num_in[i] = num_ff[i] << 1;
               rem_in[i] = vge[i] ? vdiff[i][DEN_W-1:0] : vtrial[i][DEN_W-1:0];
               vq_in[i]  = {vq_ff[i][VOLT_W-2:0], vge[i]};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = C_COMP;
            end
         end
         C_COMP: begin
            for (int i = 0; i < LANES; i++) begin
               comp_in[i] = comp_val[i];
            end
            state_in = C_LOAD;
         end
         C_LOAD: begin
            for (int i = 0; i < LANES; i++) begin
               sqp_in[i] = {COMP_W'(0), comp_ff[i]};
            end
            gk_in    = GK_W'(cfg.coupling_gain) * GK_W'(HUNDRED);
            snum_in  = SWR_NUM_W'(csum) * SWR_NUM_W'(HUNDRED);
            sden_in  = SWR_DEN_W'(comp_ff[0]) - SWR_DEN_W'(comp_ff[1]);
            srem_in  = '0;
            gamma_in = (GAM_W'(comp_ff[1]) * GAM_W'(HUNDRED)) >
                       (GAM_W'(comp_ff[0]) * GAM_W'(GAMMA_NUM));
            scnt_in  = SCNT_W'(SWR_NUM_W);
            step_in  = STEP_W'(COMP_W);
            state_in = C_SQR;
         end
         C_SQR: begin
            for (int i = 0; i < LANES; i++) begin
               sqp_in[i] = {sq_sum[i], sqp_ff[i][COMP_W-1:1]};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = C_GLOAD;
            end
         end
         C_GLOAD: begin
            for (int i = 0; i < LANES; i++) begin
               pg_in[i] = {SQ_W'(0), gk_ff};
            end
            step_in  = STEP_W'(GK_W);
            state_in = C_GAIN;
         end
         C_GAIN: begin
            for (int i = 0; i < LANES; i++) begin
               pg_in[i] = {pg_sum[i], pg_ff[i][GK_W-1:1]};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = C_RES;
            end
         end
         C_RES: begin
            res_in.fwd_voltage = vq_ff[0];
            res_in.ref_voltage = vq_ff[1];
            res_in.fwd_power   = pwr[0];
            res_in.ref_power   = pwr[1];
            if (vq_ff[0] <= VOLT_W'(V_SWR_MIN)) begin
               res_in.swr_value = SWR_W'(SWR_ONE);
            end else if (gamma_ff) begin
               res_in.swr_value = SWR_W'(SWR_CAP);
            end else begin
               res_in.swr_value = squot_ff;
            end
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase

      // SWR divider runs alongside both multiply phases
      if (scnt_ff != '0) begin
         snum_in  = snum_ff << 1;
         srem_in  = sge ? sdiff[SWR_DEN_W-1:0] : strial[SWR_DEN_W-1:0];
         squot_in = {squot_ff[SWR_W-2:0], sge};
         scnt_in  = scnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         step_ff  <= '0;
         scnt_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         scnt_ff  <= scnt_in;
         done_ff  <= (state_ff == C_RES);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LANES; i++) begin
         num_ff[i]  <= num_in[i];
         rem_ff[i]  <= rem_in[i];
         vq_ff[i]   <= vq_in[i];
         comp_ff[i] <= comp_in[i];
         sqp_ff[i]  <= sqp_in[i];
         pg_ff[i]   <= pg_in[i];
      end
      gk_ff    <= gk_in;
      snum_ff  <= snum_in;
      sden_ff  <= sden_in;
      srem_ff  <= srem_in;
      squot_ff <= squot_in;
      gamma_ff <= gamma_in;
      res_ff   <= res_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule

// ===== hdl/rf_power_swr_meter.sv =====
// Top level of the RF power and SWR meter: averaging, peak hold, alert, registers
//
//   port group   direction   handshake       payload
//   req_         in          valid / stall   rfsm_req_type
//   rsp_         out         valid / stall   rfsm_rsp_type
//   csr_         in          valid / ready   csr_index, csr_data
//
// Ticks and samples are accepted while req_stall is low. The SAMPLES-th sample
// starts the bit-serial datapath (a one-bit-per-cycle voltage divider and two
// shift-add multipliers); req_stall stays high until its reading is loaded into
// the output register. reset is synchronous and restores config, sums, hold and
// alert. rsp_stall holds the output register; samples keep flowing until the next
// SAMPLES-th sample, and req_stall then stays high until the held reading is taken.
module rf_power_swr_meter
   import rfsm_pkg::*;
#(
   parameter int SAMPLES = DEF_SAMPLES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rfsm_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rfsm_rsp_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SUM_W = $clog2(SAMPLES * SAMPLE_MAX + 1);
   localparam int CNT_W = $clog2(SAMPLES + 1);

   typedef enum logic [2:0] {
      T_IDLE = 3'b001,
      T_CALC = 3'b010,
      T_OUT  = 3'b100
   } top_state_type;

   top_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SUM_W-1:0]  fwd_sum_ff, fwd_sum_in;
   logic [SUM_W-1:0]  ref_sum_ff, ref_sum_in;
   logic [PWR_W-1:0]  peak_pwr_ff, peak_pwr_in;
   logic [SWR_W-1:0]  peak_swr_ff, peak_swr_in;
   logic [MS_W-1:0]   since_ff, since_in;
   logic              alert_ff, alert_in;
   rfsm_cfg_type      cfg_ff, cfg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rfsm_rsp_type      rsp_data_ff, rsp_data_in;

   logic              req_accept;
   logic              out_free;
   logic              is_tick;
   logic              last_sample;
   logic              calc_start;
   logic              calc_done;
   rfsm_calc_type     calc_res;
   logic [SUM_W-1:0]  fwd_add;
   logic [SUM_W-1:0]  ref_add;

   logic [PWR_W-1:0]  new_pwr;
   logic [SWR_W-1:0]  new_swr;
   logic              new_alert;
   logic              clr_since;

   assign req_stall   = (state_ff != T_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign is_tick     = (req_data.command == CMD_TICK);
   assign last_sample = (cnt_ff == CNT_W'(SAMPLES - 1));
   assign fwd_add     = fwd_sum_ff + SUM_W'(req_data.fwd_sample);
   assign ref_add     = ref_sum_ff + SUM_W'(req_data.ref_sample);
   assign calc_start  = req_accept && !is_tick && last_sample;

   rfsm_calc #(
      .SAMPLES (SAMPLES)
   ) u_calc (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .start   (calc_start),
      .fwd_sum (fwd_add),
      .ref_sum (ref_add),
      .done    (calc_done),
      .res     (calc_res)
   );

   // peak hold and alert
   always_comb begin
      new_pwr   = peak_pwr_ff;
      new_swr   = peak_swr_ff;
      clr_since = 1'b0;
      if (calc_res.fwd_power >= peak_pwr_ff) begin
         new_pwr   = calc_res.fwd_power;
         clr_since = 1'b1;
         if (calc_res.swr_value > peak_swr_ff) begin
            new_swr = calc_res.swr_value;
         end
      end else if (since_ff > cfg_ff.hold_time_ms) begin
         new_pwr = calc_res.fwd_power;
         new_swr = calc_res.swr_value;
      end
      if (new_swr >= cfg_ff.alert_swr && calc_res.fwd_power > PWR_W'(ALERT_PWR)) begin
         new_alert = 1'b1;
      end else if (new_swr < cfg_ff.alert_swr) begin
         new_alert = 1'b0;
      end else begin
         new_alert = alert_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fwd_sum_in   = fwd_sum_ff;
      ref_sum_in   = ref_sum_ff;
      peak_pwr_in  = peak_pwr_ff;
      peak_swr_in  = peak_swr_ff;
      since_in     = since_ff;
      alert_in     = alert_ff;
      cfg_in       = cfg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         T_IDLE: begin
            if (req_accept) begin
               if (is_tick) begin
                  if (since_ff != '1) begin
                     since_in = since_ff + 1'b1;
                  end
               end else if (last_sample) begin
                  cnt_in     = '0;
                  fwd_sum_in = '0;
                  ref_sum_in = '0;
                  state_in   = T_CALC;
               end else begin
                  cnt_in     = cnt_ff + 1'b1;
                  fwd_sum_in = fwd_add;
                  ref_sum_in = ref_add;
               end
            end
         end
         T_CALC: begin
            if (calc_done) begin
               state_in = T_OUT;
            end
         end
         T_OUT: begin
            if (out_free) begin
               peak_pwr_in = new_pwr;
               peak_swr_in = new_swr;
               alert_in    = new_alert;
               if (clr_since) begin
                  since_in = '0;
               end
               rsp_data_in.fwd_voltage = calc_res.fwd_voltage;
               rsp_data_in.ref_voltage = calc_res.ref_voltage;
               rsp_data_in.fwd_power   = calc_res.fwd_power;
               rsp_data_in.ref_power   = calc_res.ref_power;
               rsp_data_in.swr_value   = calc_res.swr_value;
               rsp_data_in.held_power  = new_pwr;
               rsp_data_in.held_swr    = new_swr;
               rsp_data_in.swr_shown   = (calc_res.fwd_power >= PWR_W'(SHOWN_MIN));
               rsp_data_in.alert       = new_alert;
               rsp_valid_in            = 1'b1;
               state_in                = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COUPLING_GAIN: cfg_in.coupling_gain = csr_data[GAIN_W-1:0];
            CSR_DIODE_DROP:    cfg_in.diode_drop    = csr_data[DROP_W-1:0];
            CSR_HOLD_TIME_MS:  cfg_in.hold_time_ms  = csr_data[HOLD_W-1:0];
            CSR_ALERT_SWR:     cfg_in.alert_swr     = csr_data[ALERT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         cnt_ff       <= '0;
         fwd_sum_ff   <= '0;
         ref_sum_ff   <= '0;
         peak_pwr_ff  <= '0;
         peak_swr_ff  <= SWR_W'(SWR_ONE);
         since_ff     <= '0;
         alert_ff     <= 1'b0;
         cfg_ff       <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fwd_sum_ff   <= fwd_sum_in;
         ref_sum_ff   <= ref_sum_in;
         peak_pwr_ff  <= peak_pwr_in;
         peak_swr_ff  <= peak_swr_in;
         since_ff     <= since_in;
         alert_ff     <= alert_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

// ===== hdl/rfsm_checker.sv =====
// Port-level assertions for the RF power and SWR meter, bound to the top level
module rfsm_checker
   import rfsm_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input rfsm_req_type req_data,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rfsm_rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a tick never starts the datapath
   a_tick_no_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.command == CMD_TICK |=> !req_stall)
      else $error("tick transfer stalled the input");

   // a new result only comes out of a busy datapath
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a busy phase");

   // low forward voltage reads SWR 1.00
   a_low_fwd_swr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fwd_voltage <= VOLT_W'(V_SWR_MIN) |->
         rsp_data.swr_value == SWR_W'(SWR_ONE))
      else $error("SWR not 1.00 at low forward voltage");

endmodule

bind rf_power_swr_meter rfsm_checker u_rfsm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
